// ===== src/dfhe_pkg.sv =====
package dfhe_pkg;

  typedef enum logic [1:0] {
    KIND_LIT  = 2'd0,
    KIND_LEN  = 2'd1,
    KIND_DIST = 2'd2
  } kind_e;

  localparam int unsigned BITS_W  = 18;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned VALUE_W = 16;

  localparam logic [15:0] SYM_MAX  = 16'd285;
  localparam logic [15:0] LEN_MIN  = 16'd3;
  localparam logic [15:0] LEN_MAX  = 16'd258;
  localparam logic [15:0] DIST_MAX = 16'd32768;

  localparam logic [8:0] LEN_CODE_BASE = 9'd257;
  localparam logic [8:0] LEN_SYM_MAX   = 9'd285;

  typedef struct packed {
    logic [BITS_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    logic              bad;
  } enc_result_t;

  typedef struct packed {
    logic [8:0] code_rev;
    logic [3:0] len;
  } sym_code_t;

  // length offsets from 3, per length code 257..284
  localparam logic [7:0] LEN_BASE [28] = '{
    8'd0,   8'd1,   8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,
    8'd8,   8'd10,  8'd12,  8'd14,  8'd16,  8'd20,  8'd24,  8'd28,
    8'd32,  8'd40,  8'd48,  8'd56,  8'd64,  8'd80,  8'd96,  8'd112,
    8'd128, 8'd160, 8'd192, 8'd224
  };

  localparam logic [2:0] LEN_EXTRA [28] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5
  };

  // distance offsets from 1, per distance code 0..29
  localparam logic [14:0] DIST_BASE [30] = '{
    15'd0,     15'd1,     15'd2,     15'd3,     15'd4,     15'd6,
    15'd8,     15'd12,    15'd16,    15'd24,    15'd32,    15'd48,
    15'd64,    15'd96,    15'd128,   15'd192,   15'd256,   15'd384,
    15'd512,   15'd768,   15'd1024,  15'd1536,  15'd2048,  15'd3072,
    15'd4096,  15'd6144,  15'd8192,  15'd12288, 15'd16384, 15'd24576
  };

  localparam logic [3:0] DIST_EXTRA [30] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3,
    4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8,
    4'd9, 4'd9, 4'd10, 4'd10, 4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
  };

  function automatic logic [8:0] rev9(logic [8:0] v);
    logic [8:0] r;
    for (int i = 0; i < 9; i++) begin
      r[i] = v[8-i];
    end
    return r;
  endfunction

  function automatic logic [4:0] rev5(logic [4:0] v);
    logic [4:0] r;
    for (int i = 0; i < 5; i++) begin
      r[i] = v[4-i];
    end
    return r;
  endfunction

  // fixed literal/length code, reversed for LSB-first output
  function automatic sym_code_t fixed_sym(logic [8:0] sym);
    logic [8:0] c;
    logic [3:0] n;
    sym_code_t  r;
    if (sym <= 9'd143) begin
      c = sym + 9'h030;
      n = 4'd8;
    end else if (sym <= 9'd255) begin
      c = sym + 9'h100;
      n = 4'd9;
    end else if (sym <= 9'd279) begin
      c = sym - 9'd256;
      n = 4'd7;
    end else begin
      c = sym - 9'd88;
      n = 4'd8;
    end
    r.code_rev = rev9(c) >> (4'd9 - n);
    r.len      = n;
    return r;
  endfunction

endpackage

// ===== src/dfhe_encode.sv =====
module dfhe_encode
  import dfhe_pkg::*;
(
  input  logic [1:0]         kind_i,
  input  logic [VALUE_W-1:0] value_i,
  output enc_result_t        result_o
);

  logic [7:0]  len_v;
  logic [4:0]  len_code;
  logic [7:0]  len_ext;
  sym_code_t   len_sym;
  sym_code_t   lit_sym;
  logic [14:0] dist_v;
  logic [4:0]  dist_code;
  logic [14:0] dist_ext;

  always_comb begin
    // length: offset from 3, code search over increasing bases
    len_v    = value_i[7:0] - 8'd3;
    len_code = 5'd0;
    for (int i = 1; i < 28; i++) begin
      if (len_v >= LEN_BASE[i]) begin
        len_code = 5'(i);
      end
    end
    len_ext = len_v - LEN_BASE[len_code];
    if (value_i == LEN_MAX) begin
      len_sym = fixed_sym(LEN_SYM_MAX);
    end else begin
      len_sym = fixed_sym(LEN_CODE_BASE + {4'd0, len_code});
    end

    dist_v    = value_i[14:0] - 15'd1;
    dist_code = 5'd0;
    for (int i = 1; i < 30; i++) begin
      if (dist_v >= DIST_BASE[i]) begin
        dist_code = 5'(i);
      end
    end
    dist_ext = dist_v - DIST_BASE[dist_code];

    lit_sym = fixed_sym(value_i[8:0]);
  end

  always_comb begin
    result_o = '0;
    unique case (kind_e'(kind_i))
      KIND_LIT: begin
        if (value_i > SYM_MAX) begin
          result_o.bad = 1'b1;
        end else begin
          result_o.bits = {9'd0, lit_sym.code_rev};
          result_o.len  = {1'b0, lit_sym.len};
        end
      end
      KIND_LEN: begin
        if (value_i < LEN_MIN || value_i > LEN_MAX) begin
          result_o.bad = 1'b1;
        end else if (value_i == LEN_MAX) begin
          result_o.bits = {9'd0, len_sym.code_rev};
          result_o.len  = {1'b0, len_sym.len};
        end else begin
          result_o.bits = {9'd0, len_sym.code_rev} | ({10'd0, len_ext} << len_sym.len);
          result_o.len  = {1'b0, len_sym.len} + {2'd0, LEN_EXTRA[len_code]};
        end
      end
      KIND_DIST: begin
        if (value_i == 16'd0 || value_i > DIST_MAX) begin
          result_o.bad = 1'b1;
        end else begin
          result_o.bits = {13'd0, rev5(dist_code)} | ({3'd0, dist_ext} << 5);
          result_o.len  = 5'd5 + {1'b0, DIST_EXTRA[dist_code]};
        end
      end
      default: begin
        result_o.bad = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/deflate_fixed_huffman_encoder_unit.sv =====
// Fixed-Huffman DEFLATE token encoder.
// A word taken at start_i passes the input register, then the result register;
// out_valid_o is registered together with the result register.
// Throughput: one word per cycle; busy_o stays low, the receiver cannot stall.
// Reset: rst_ni asynchronous, active low; clears the valid flags only.
module deflate_fixed_huffman_encoder_unit
  import dfhe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         kind_i,
  input  logic [VALUE_W-1:0] token_value_i,
  output logic               out_valid_o,
  output logic [BITS_W-1:0]  code_bits_o,
  output logic [LEN_W-1:0]   code_length_o,
  output logic               bad_value_o
);

  logic               in_valid_q;
  logic [1:0]         kind_q;
  logic [VALUE_W-1:0] value_q;
  logic               out_valid_q;
  enc_result_t        res_d;
  enc_result_t        res_q;
  logic               accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= accept;
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      value_q <= token_value_i;
    end
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  dfhe_encode u_encode (
    .kind_i   (kind_q),
    .value_i  (value_q),
    .result_o (res_d)
  );

  assign out_valid_o   = out_valid_q;
  assign code_bits_o   = res_q.bits;
  assign code_length_o = res_q.len;
  assign bad_value_o   = res_q.bad;

endmodule

// ===== src/dfhe_checker.sv =====
module dfhe_checker
  import dfhe_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               out_valid_o,
  input logic [BITS_W-1:0]  code_bits_o,
  input logic [LEN_W-1:0]   code_length_o,
  input logic               bad_value_o
);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 out_valid_o)
    else $error("accepted word gave no result two cycles later");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start_i && !busy_o, 2))
    else $error("result without an accepted word");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_value_o |-> code_length_o == '0 && code_bits_o == '0)
    else $error("error result carries bits");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_value_o |-> code_length_o >= 5'd5 && code_length_o <= 5'd18)
    else $error("code length out of range");

endmodule

bind deflate_fixed_huffman_encoder_unit dfhe_checker u_dfhe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .out_valid_o   (out_valid_o),
  .code_bits_o   (code_bits_o),
  .code_length_o (code_length_o),
  .bad_value_o   (bad_value_o)
);
